@@ sv/ssfr_pkg.sv @@
// shared types and constants of the servo status frame receiver
`timescale 1ns / 1ps

package ssfr_pkg;

    // bus framing constants
    localparam logic [7:0] HDR_BYTE       = 8'hFF;
    localparam logic [7:0] LEN_CEIL       = 8'd251;
    localparam logic [7:0] FRAME_OVERHEAD = 8'd4;
    localparam logic [7:0] TICK_SAT       = 8'hFF;

    // register reset values
    localparam logic [7:0] MAX_LENGTH_RST    = 8'd139;
    localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd5;

    // register indexes
    localparam logic REG_MAX_LENGTH    = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    // command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // result status codes
    localparam logic [2:0] ST_IGNORED = 3'd0;
    localparam logic [2:0] ST_STORED  = 3'd1;
    localparam logic [2:0] ST_GOOD    = 3'd2;
    localparam logic [2:0] ST_BADSUM  = 3'd3;
    localparam logic [2:0] ST_TIMEOUT = 3'd4;
    localparam logic [2:0] ST_DROPPED = 3'd5;

    typedef struct packed {
        logic [7:0] max_length;
        logic [7:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] byte_out;
        logic [7:0] byte_index;
        logic [7:0] frame_length;
    } result_t;

endpackage

@@ sv/servo_status_frame_receiver_unit.sv @@
// top level of the servo status frame receiver
`timescale 1ns / 1ps
// path: a command beat passes through the input register, then the state update into the result register
// throughput: one command beat per cycle while result beats are taken, one result beat per command beat
// a stalled result beat holds the result register, s_tready falls once the input register fills too
// reset: synchronous active-low aresetn empties both stages, sends the hunt idle,
// clears all counters and loads max_length 139 and timeout_ticks 5

module servo_status_frame_receiver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // command beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] byte_out, [15:8] byte_index, [23:16] frame_length
    output logic [2:0]  m_tuser,   // [2:0] status
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    ssfr_pkg::cfg_t    cfg;
    ssfr_pkg::item_t   s_item;
    ssfr_pkg::item_t   st_item;
    logic              st_valid;
    logic              st_ready;
    ssfr_pkg::result_t result;

    // register 0 at byte address 0, register 1 at 4
    ssfr_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_o   (cfg)
    );

    assign s_item.cmd     = s_tuser;
    assign s_item.rx_byte = s_tdata;

    // input register
    ssfr_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid_i (s_tvalid),
        .s_item_i  (s_item),
        .s_ready_o (s_tready),
        .valid_o   (st_valid),
        .item_o    (st_item),
        .ready_i   (st_ready)
    );

    // per-beat state update and result register
    ssfr_frame_fsm u_fsm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_i      (cfg),
        .valid_i    (st_valid),
        .item_i     (st_item),
        .ready_o    (st_ready),
        .m_valid_o  (m_tvalid),
        .m_result_o (result),
        .m_ready_i  (m_tready)
    );

    assign m_tdata = {result.frame_length, result.byte_index, result.byte_out};
    assign m_tuser = result.status;

endmodule

@@ sv/ssfr_apb_regs.sv @@
// apb register file holding the receiver configuration
`timescale 1ns / 1ps

module ssfr_apb_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output ssfr_pkg::cfg_t cfg_o
);

    ssfr_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic           reg_sel;

    // word address only, byte lane bits ignored
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_length    <= ssfr_pkg::MAX_LENGTH_RST;
            cfg_reg.timeout_ticks <= ssfr_pkg::TIMEOUT_TICKS_RST;
        end else if (wr_en) begin
            if (reg_sel == ssfr_pkg::REG_MAX_LENGTH) begin
                cfg_reg.max_length <= pwdata[7:0];
            end else begin
                cfg_reg.timeout_ticks <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        if (reg_sel == ssfr_pkg::REG_MAX_LENGTH) begin
            prdata = {24'd0, cfg_reg.max_length};
        end else begin
            prdata = {24'd0, cfg_reg.timeout_ticks};
        end
    end

    assign cfg_o = cfg_reg;

endmodule

@@ sv/ssfr_in_stage.sv @@
// input register stage for command beats
`timescale 1ns / 1ps

module ssfr_in_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid_i,
    input  ssfr_pkg::item_t s_item_i,
    output logic            s_ready_o,
    output logic            valid_o,
    output ssfr_pkg::item_t item_o,
    input  logic            ready_i
);

    logic            valid_reg;
    ssfr_pkg::item_t item_reg;

    assign s_ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready_o) begin
            valid_reg <= s_valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready_o && s_valid_i) begin
            item_reg <= s_item_i;
        end
    end

    assign valid_o = valid_reg;
    assign item_o  = item_reg;

endmodule

@@ sv/ssfr_frame_fsm.sv @@
// frame hunt state machine, checksum, tick timeout and result register
`timescale 1ns / 1ps

module ssfr_frame_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  ssfr_pkg::cfg_t    cfg_i,
    input  logic              valid_i,
    input  ssfr_pkg::item_t   item_i,
    output logic              ready_o,
    output logic              m_valid_o,
    output ssfr_pkg::result_t m_result_o,
    input  logic              m_ready_i
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FF1,
        PH_FF2,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [7:0]        taken_reg, taken_next;
    logic [7:0]        total_reg, total_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        ticks_reg, ticks_next;
    logic              out_valid_reg;
    ssfr_pkg::result_t result_reg, result_next;
    logic              advance;
    logic [7:0]        b;
    logic [7:0]        taken_inc;
    logic [7:0]        sum_add;
    logic              len_ok;

    assign ready_o = !out_valid_reg || m_ready_i;
    assign advance = valid_i && ready_o;
    assign b       = item_i.rx_byte;
    assign taken_inc = taken_reg + 8'd1;
    assign sum_add   = sum_reg + b;
    assign len_ok    = (b != 8'd0) && (b <= cfg_i.max_length) && (b <= ssfr_pkg::LEN_CEIL);

    always_comb begin
        phase_next  = phase_reg;
        taken_next  = taken_reg;
        total_next  = total_reg;
        sum_next    = sum_reg;
        ticks_next  = ticks_reg;
        result_next = '{status: ssfr_pkg::ST_IGNORED, byte_out: 8'd0,
                        byte_index: 8'd0, frame_length: 8'd0};
        case (item_i.cmd)
            ssfr_pkg::CMD_START: begin
                phase_next = PH_FF1;
                taken_next = 8'd0;
                total_next = 8'd0;
                sum_next   = 8'd0;
                ticks_next = 8'd0;
            end
            ssfr_pkg::CMD_BYTE: begin
                case (phase_reg)
                    PH_FF1: begin
                        if (b == ssfr_pkg::HDR_BYTE) begin
                            result_next.status   = ssfr_pkg::ST_STORED;
                            result_next.byte_out = b;
                            taken_next = 8'd1;
                            phase_next = PH_FF2;
                        end else begin
                            result_next.status = ssfr_pkg::ST_DROPPED;
                        end
                    end
                    PH_FF2: begin
                        if (b == ssfr_pkg::HDR_BYTE) begin
                            result_next.status     = ssfr_pkg::ST_STORED;
                            result_next.byte_out   = b;
                            result_next.byte_index = taken_reg;
                            taken_next = taken_inc;
                            phase_next = PH_ID;
                        end else begin
                            result_next.status = ssfr_pkg::ST_DROPPED;
                            phase_next = PH_FF1;
                        end
                    end
                    PH_ID: begin
                        // extra header bytes before the id are skipped
                        if (b != ssfr_pkg::HDR_BYTE) begin
                            result_next.status     = ssfr_pkg::ST_STORED;
                            result_next.byte_out   = b;
                            result_next.byte_index = taken_reg;
                            taken_next = taken_inc;
                            sum_next   = b;
                            phase_next = PH_LEN;
                        end else begin
                            result_next.status = ssfr_pkg::ST_DROPPED;
                        end
                    end
                    PH_LEN: begin
                        if (len_ok) begin
                            result_next.status     = ssfr_pkg::ST_STORED;
                            result_next.byte_out   = b;
                            result_next.byte_index = taken_reg;
                            taken_next = taken_inc;
                            sum_next   = sum_add;
                            total_next = b + ssfr_pkg::FRAME_OVERHEAD;
                            phase_next = PH_BODY;
                        end else begin
                            result_next.status = ssfr_pkg::ST_DROPPED;
                            phase_next = PH_FF1;
                        end
                    end
                    PH_BODY: begin
                        result_next.status     = ssfr_pkg::ST_STORED;
                        result_next.byte_out   = b;
                        result_next.byte_index = taken_reg;
                        taken_next = taken_inc;
                        sum_next   = sum_add;
                        if (taken_inc == total_reg) begin
                            if (sum_add == ssfr_pkg::HDR_BYTE) begin
                                result_next.status       = ssfr_pkg::ST_GOOD;
                                result_next.frame_length = total_reg;
                                phase_next = PH_IDLE;
                            end else begin
                                result_next.status = ssfr_pkg::ST_BADSUM;
                                phase_next = PH_FF1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ssfr_pkg::CMD_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (ticks_reg != ssfr_pkg::TICK_SAT) begin
                        ticks_next = ticks_reg + 8'd1;
                    end
                    if (ticks_next >= cfg_i.timeout_ticks) begin
                        phase_next = PH_IDLE;
                        result_next.status = ssfr_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            taken_reg     <= 8'd0;
            total_reg     <= 8'd0;
            sum_reg       <= 8'd0;
            ticks_reg     <= 8'd0;
            out_valid_reg <= 1'b0;
            result_reg    <= '0;
        end else begin
            if (advance) begin
                phase_reg     <= phase_next;
                taken_reg     <= taken_next;
                total_reg     <= total_next;
                sum_reg       <= sum_next;
                ticks_reg     <= ticks_next;
                out_valid_reg <= 1'b1;
                result_reg    <= result_next;
            end else if (m_ready_i) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid_o  = out_valid_reg;
    assign m_result_o = result_reg;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench of the servo status frame receiver: directed and random beats
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;

    typedef enum logic [2:0] {
        HUNT_IDLE,
        HUNT_FF1,
        HUNT_FF2,
        HUNT_ID,
        HUNT_LEN,
        HUNT_BODY
    } hunt_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [1:0]  s_tuser  = ssfr_pkg::CMD_START;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    servo_status_frame_receiver_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // mirror of the receiver state and its registers
    ssfr_pkg::cfg_t cfg_mirror  = '{max_length: ssfr_pkg::MAX_LENGTH_RST,
                                    timeout_ticks: ssfr_pkg::TIMEOUT_TICKS_RST};
    hunt_t       hunt        = HUNT_IDLE;
    logic [7:0]  bytes_kept  = '0;
    logic [7:0]  frame_total = '0;
    logic [7:0]  run_sum     = '0;
    logic [7:0]  tick_count  = '0;

    ssfr_pkg::result_t status_q[$];
    int unsigned err_count     = 0;
    int unsigned beats_sent    = 0;
    int unsigned beats_checked = 0;
    int unsigned reg_writes    = 0;
    int unsigned status_seen[8];
    bit          quiet_run     = 1'b0;

    initial begin : clock_gen
        forever #2 aclk = ~aclk;
    end

    // mostly short gaps, a few long ones, none during a quiet stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_run) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic ssfr_pkg::result_t stored_beat(input logic [7:0] b);
        ssfr_pkg::result_t r;
        r = '0;
        r.status     = ssfr_pkg::ST_STORED;
        r.byte_out   = b;
        r.byte_index = bytes_kept;
        bytes_kept   = bytes_kept + 8'd1;
        return r;
    endfunction

    // next state of the hunt and the status beat one command beat causes
    function automatic ssfr_pkg::result_t predict_status_beat(input logic [1:0] cmd,
                                                              input logic [7:0] b);
        ssfr_pkg::result_t r;
        r = '0;
        case (cmd)
            ssfr_pkg::CMD_START: begin
                hunt        = HUNT_FF1;
                bytes_kept  = '0;
                frame_total = '0;
                run_sum     = '0;
                tick_count  = '0;
            end
            ssfr_pkg::CMD_BYTE: begin
                case (hunt)
                    HUNT_FF1: begin
                        if (b == ssfr_pkg::HDR_BYTE) begin
                            bytes_kept = '0;
                            r = stored_beat(b);
                            hunt = HUNT_FF2;
                        end else begin
                            r.status = ssfr_pkg::ST_DROPPED;
                        end
                    end
                    HUNT_FF2: begin
                        if (b == ssfr_pkg::HDR_BYTE) begin
                            r = stored_beat(b);
                            hunt = HUNT_ID;
                        end else begin
                            r.status = ssfr_pkg::ST_DROPPED;
                            hunt = HUNT_FF1;
                        end
                    end
                    HUNT_ID: begin
                        if (b != ssfr_pkg::HDR_BYTE) begin
                            r = stored_beat(b);
                            run_sum = b;
                            hunt = HUNT_LEN;
                        end else begin
                            r.status = ssfr_pkg::ST_DROPPED;
                        end
                    end
                    HUNT_LEN: begin
                        if (b >= 8'd1 && b <= cfg_mirror.max_length
                            && b <= ssfr_pkg::LEN_CEIL) begin
                            r = stored_beat(b);
                            run_sum = run_sum + b;
                            frame_total = b + ssfr_pkg::FRAME_OVERHEAD;
                            hunt = HUNT_BODY;
                        end else begin
                            r.status = ssfr_pkg::ST_DROPPED;
                            hunt = HUNT_FF1;
                        end
                    end
                    HUNT_BODY: begin
                        r = stored_beat(b);
                        run_sum = run_sum + b;
                        if (bytes_kept == frame_total) begin
                            if (run_sum == ssfr_pkg::HDR_BYTE) begin
                                r.status = ssfr_pkg::ST_GOOD;
                                r.frame_length = frame_total;
                                hunt = HUNT_IDLE;
                            end else begin
                                r.status = ssfr_pkg::ST_BADSUM;
                                hunt = HUNT_FF1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ssfr_pkg::CMD_TICK: begin
                if (hunt != HUNT_IDLE) begin
                    if (tick_count < ssfr_pkg::TICK_SAT) tick_count = tick_count + 8'd1;
                    if (tick_count >= cfg_mirror.timeout_ticks) begin
                        hunt = HUNT_IDLE;
                        r.status = ssfr_pkg::ST_TIMEOUT;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // one command beat, after a random gap; the expectation is queued on acceptance
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b);
        int unsigned       gap;
        ssfr_pkg::result_t r;
        gap = pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = predict_status_beat(cmd, b);
        status_q.push_back(r);
        status_seen[r.status]++;
        beats_sent++;
    endtask

    // whole frame; the last body byte closes the checksum unless corrupted
    task automatic send_frame(input logic [7:0] id, input logic [7:0] len,
                              input bit corrupt, input bit extra_ff);
        logic [7:0]  sum;
        logic [7:0]  b;
        int unsigned i;
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        if (extra_ff) send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, id);
        send_beat(ssfr_pkg::CMD_BYTE, len);
        sum = id + len;
        for (i = 1; i < len; i++) begin
            b = 8'($urandom);
            sum = sum + b;
            send_beat(ssfr_pkg::CMD_BYTE, b);
        end
        b = ssfr_pkg::HDR_BYTE - sum;
        if (corrupt) b = b + 8'($urandom_range(1, 255));
        send_beat(ssfr_pkg::CMD_BYTE, b);
    endtask

    // sender quiet until every status beat is back, plus the pipeline depth
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apb_transfer(input logic write, input logic [2:0] addr,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // register write while idle, then read back
    task automatic write_register(input logic reg_idx, input logic [7:0] value);
        logic [31:0] rd;
        wait_idle();
        apb_transfer(1'b1, {reg_idx, 2'b00}, {24'd0, value}, rd);
        case (reg_idx)
            ssfr_pkg::REG_MAX_LENGTH:    cfg_mirror.max_length    = value;
            ssfr_pkg::REG_TIMEOUT_TICKS: cfg_mirror.timeout_ticks = value;
            default: ;
        endcase
        reg_writes++;
        apb_transfer(1'b0, {reg_idx, 2'b00}, '0, rd);
        if (rd[7:0] !== value) begin
            $error("register %0d readback expected %0h actual %0h", reg_idx, value, rd[7:0]);
            err_count++;
        end
    endtask

    task automatic test_idle_and_unused();
        send_beat(ssfr_pkg::CMD_BYTE, 8'hA5);
        send_beat(ssfr_pkg::CMD_TICK, 8'h00);
        send_beat(CMD_UNUSED, 8'hFF);
    endtask

    task automatic test_header_hunt();
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h00);      // junk before the header
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h5A);      // second header byte wrong
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);   // surplus 0xff skipped before the id
        send_beat(ssfr_pkg::CMD_BYTE, 8'hFE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h00);      // zero length
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h00);
        send_beat(ssfr_pkg::CMD_BYTE, 8'd140);     // just above the reset maximum
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h01);
        send_beat(ssfr_pkg::CMD_START, 8'hFF);     // restart in the middle of a frame
        send_frame(8'h00, 8'd1, 1'b0, 1'b0);
    endtask

    task automatic test_timeout();
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        repeat (5) send_beat(ssfr_pkg::CMD_TICK, 8'h00);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);   // idle again after the timeout
    endtask

    task automatic test_register_extremes();
        write_register(ssfr_pkg::REG_MAX_LENGTH, 8'd1);
        write_register(ssfr_pkg::REG_TIMEOUT_TICKS, 8'd255);
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_frame(8'h10, 8'd1, 1'b0, 1'b0);
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h10);
        send_beat(ssfr_pkg::CMD_BYTE, 8'd2);
        send_frame(8'h20, 8'd1, 1'b1, 1'b0);
        send_frame(8'h7F, 8'd1, 1'b0, 1'b0);  // hunt resumes after a bad checksum
        repeat (3) send_beat(ssfr_pkg::CMD_TICK, 8'h00);

        // longest frame the block takes: index 254, total 255
        write_register(ssfr_pkg::REG_MAX_LENGTH, ssfr_pkg::LEN_CEIL);
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_frame(8'($urandom_range(0, 254)), ssfr_pkg::LEN_CEIL, 1'b0, 1'b0);

        // maximum above the ceiling still rejects long lengths
        write_register(ssfr_pkg::REG_MAX_LENGTH, 8'd255);
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h01);
        send_beat(ssfr_pkg::CMD_BYTE, 8'd252);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_BYTE, 8'h01);
        send_beat(ssfr_pkg::CMD_BYTE, 8'd255);

        // zero timeout expires on the first tick
        write_register(ssfr_pkg::REG_TIMEOUT_TICKS, 8'd0);
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_beat(ssfr_pkg::CMD_TICK, 8'h00);
        write_register(ssfr_pkg::REG_TIMEOUT_TICKS, 8'd1);
        send_beat(ssfr_pkg::CMD_START, 8'h00);
        send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
        send_beat(ssfr_pkg::CMD_TICK, 8'h00);
        send_beat(ssfr_pkg::CMD_TICK, 8'h00);
    endtask

    function automatic logic [7:0] pick_max_length();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'd1;
        if (r < 22) return ssfr_pkg::LEN_CEIL;
        if (r < 27) return 8'd255;
        if (r < 30) return 8'd0;
        return 8'($urandom_range(2, 12));
    endfunction

    function automatic logic [7:0] pick_timeout();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 20) return 8'd1;
        if (r < 30) return 8'd255;
        return 8'($urandom_range(2, 40));
    endfunction

    // mostly well-formed frames with random content, plus noise and broken headers
    task automatic test_random_traffic(input int unsigned n_beats, input bit quiet);
        int unsigned stop_at;
        int unsigned pause_at;
        int unsigned r;
        bit          paused;
        logic [7:0]  hi;
        logic [7:0]  len;
        write_register(ssfr_pkg::REG_MAX_LENGTH, pick_max_length());
        write_register(ssfr_pkg::REG_TIMEOUT_TICKS, pick_timeout());
        quiet_run = quiet;
        stop_at  = beats_sent + n_beats;
        pause_at = beats_sent + n_beats / 2;
        paused   = 1'b0;
        while (beats_sent < stop_at) begin
            if (!paused && beats_sent >= pause_at) begin
                wait_idle();
                paused = 1'b1;
            end
            hi = (cfg_mirror.max_length > ssfr_pkg::LEN_CEIL) ? ssfr_pkg::LEN_CEIL
                                                              : cfg_mirror.max_length;
            r = $urandom_range(0, 99);
            if (r < 6) begin
                send_beat(ssfr_pkg::CMD_START, 8'($urandom));
            end else if (r < 11) begin
                send_beat(2'($urandom_range(0, 3)), 8'($urandom));
            end else if (r < 15) begin
                send_beat(ssfr_pkg::CMD_TICK, 8'($urandom));
            end else if (r < 20) begin
                send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
                send_beat(ssfr_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
            end else begin
                if (hunt == HUNT_IDLE) send_beat(ssfr_pkg::CMD_START, 8'($urandom));
                if (r < 26) begin
                    // length outside the accepted range
                    send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
                    send_beat(ssfr_pkg::CMD_BYTE, ssfr_pkg::HDR_BYTE);
                    send_beat(ssfr_pkg::CMD_BYTE, 8'($urandom_range(0, 254)));
                    len = ($urandom_range(0, 1) == 0) ? 8'd0
                        : 8'($urandom_range(int'(hi) + 1, 255));
                    send_beat(ssfr_pkg::CMD_BYTE, len);
                end else begin
                    if (hi == 8'd0) len = 8'd1;
                    else if ($urandom_range(0, 99) < 85)
                        len = 8'($urandom_range(1, (hi < 8'd6) ? int'(hi) : 6));
                    else
                        len = 8'($urandom_range(1, int'(hi)));
                    send_frame(8'($urandom_range(0, 254)), len,
                               $urandom_range(0, 4) == 0, $urandom_range(0, 19) == 0);
                end
            end
        end
        quiet_run = 1'b0;
    endtask

    // result sink pacing, with short and long stalls
    initial begin : sink_pacing
        int unsigned stall;
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    // every status beat against the oldest expectation
    always @(posedge aclk) begin : result_check
        ssfr_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_checked++;
            if (status_q.size() == 0) begin
                $error("status beat with nothing expected: status %0d", m_tuser);
                err_count++;
            end else begin
                want = status_q.pop_front();
                if (m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tuser);
                    err_count++;
                end
                if (m_tdata[7:0] !== want.byte_out) begin
                    $error("byte_out expected %0h actual %0h", want.byte_out, m_tdata[7:0]);
                    err_count++;
                end
                if (m_tdata[15:8] !== want.byte_index) begin
                    $error("byte_index expected %0d actual %0d",
                           want.byte_index, m_tdata[15:8]);
                    err_count++;
                end
                if (m_tdata[23:16] !== want.frame_length) begin
                    $error("frame_length expected %0d actual %0d",
                           want.frame_length, m_tdata[23:16]);
                    err_count++;
                end
            end
        end
    end

    // ends the run when no beat or register access moves for too long
    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAIL servo_status_frame_receiver_unit");
        $finish;
    end

    initial begin : run_tests
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_and_unused();
        test_header_hunt();
        test_timeout();
        test_register_extremes();
        test_random_traffic(45, 1'b0);
        test_random_traffic(45, 1'b0);
        test_random_traffic(45, 1'b1);
        test_random_traffic(45, 1'b0);

        wait_idle();
        repeat (8) @(posedge aclk);

        $display("covered %0d command beats and %0d status beats over %0d register writes",
                 beats_sent, beats_checked, reg_writes);
        $display("good frames %0d, bad checksums %0d, timeouts %0d, dropped bytes %0d",
                 status_seen[ssfr_pkg::ST_GOOD], status_seen[ssfr_pkg::ST_BADSUM],
                 status_seen[ssfr_pkg::ST_TIMEOUT], status_seen[ssfr_pkg::ST_DROPPED]);
        if (err_count == 0) begin
            $display("PASS servo_status_frame_receiver_unit");
        end else begin
            $display("FAIL servo_status_frame_receiver_unit");
        end
        $finish;
    end

endmodule

@@ sim.f @@
sv/ssfr_pkg.sv
sv/ssfr_apb_regs.sv
sv/ssfr_in_stage.sv
sv/ssfr_frame_fsm.sv
sv/servo_status_frame_receiver_unit.sv
verif/tb_top.sv
